// File: sv/assert_macros.svh
// Assertion macros shared by the sorted list table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define SLT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define SLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SLT_ASSERT(lbl, clk, rst, prop, msg)
`define SLT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: sv/slt_pkg.sv
// Shared constants, codes and types of the sorted list table.
// No dependencies; imported by every module of the block.
package slt_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP_ASC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP_DESC = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  // What every cell of the chain does at a clock edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP_ASC,
    ST_DUMP_DESC
  } ctrl_state_t;

  // Command broadcast from the controller to the chain
  typedef struct packed {
    cell_op_t               op;
    logic signed [VAL_W-1:0] operand;
  } cell_cmd_t;

endpackage

// File: sv/slt_cell.sv
// One cell of the sorted chain: holds a single entry and compares it with the operand.
// Depends on slt_pkg.
module slt_cell (
  input  logic                          clk,
  input  slt_pkg::cell_cmd_t            cmd,
  input  logic                          occupied,
  input  logic                          left_lt,
  input  logic signed [slt_pkg::VAL_W-1:0] left_val,
  input  logic signed [slt_pkg::VAL_W-1:0] right_val,
  output logic signed [slt_pkg::VAL_W-1:0] val,
  output logic                          lt,
  output logic                          eq
);
  import slt_pkg::*;

  logic signed [VAL_W-1:0] val_next;

  // Compare the held entry with the broadcast operand
  assign lt = occupied && (val < cmd.operand);
  assign eq = occupied && (val == cmd.operand);

  // Choose the next entry: shift, take the operand or rotate
  always_comb begin
    val_next = val;
    case (cmd.op)
      CELL_INSERT: begin
        if (!lt) val_next = left_lt ? cmd.operand : left_val;
      end
      CELL_DELETE: begin
        if (!lt) val_next = right_val;
      end
      CELL_ROT_LEFT:  val_next = right_val;
      CELL_ROT_RIGHT: val_next = left_val;
      default:        val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// File: sv/slt_ctrl.sv
// Controller of the sorted list table: entry count, dump sequencing and output register.
// Depends on slt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slt_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [slt_pkg::MODE_W-1:0]       mode,
  input  logic signed [slt_pkg::VAL_W-1:0] value,
  input  logic [slt_pkg::DEPTH-1:0]        lt_vec,
  input  logic [slt_pkg::DEPTH-1:0]        eq_vec,
  input  logic signed [slt_pkg::VAL_W-1:0] head_val,
  input  logic signed [slt_pkg::VAL_W-1:0] tail_val,
  output slt_pkg::cell_cmd_t               cmd,
  output logic [slt_pkg::CNT_W-1:0]        count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [slt_pkg::STAT_W-1:0]       status,
  output logic signed [slt_pkg::VAL_W-1:0] entry_value,
  output logic [slt_pkg::POS_W-1:0]        position,
  output logic                             last_of_run
);
  import slt_pkg::*;

  ctrl_state_t             state, state_next;
  logic [IDX_W-1:0]        step, step_next;
  logic [CNT_W-1:0]        count_next;
  logic                    out_free, accept, found, emit, advance, load;
  logic [IDX_W-1:0]        lb_pos;
  logic [STAT_W-1:0]       status_next;
  logic signed [VAL_W-1:0] entry_next;
  logic [POS_W-1:0]        position_next;
  logic                    last_next;

  // Handshake and compare summary
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign found    = |eq_vec;
  assign lb_pos   = IDX_W'($countones(lt_vec));

  // Dump step: emit only the steps that land on a held entry
  always_comb begin
    case (state)
      ST_DUMP_ASC:  emit = CNT_W'(step) < count;
      ST_DUMP_DESC: emit = CNT_W'(step) >= (CNT_W'(DEPTH) - count);
      default:      emit = 1'b0;
    endcase
  end
  assign advance = !emit || out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && count != '0) begin
          if (mode == MODE_DUMP_ASC)  state_next = ST_DUMP_ASC;
          if (mode == MODE_DUMP_DESC) state_next = ST_DUMP_DESC;
        end
      end
      ST_DUMP_ASC, ST_DUMP_DESC: begin
        if (advance && step == IDX_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: cell command, count, step and the next result beat
  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.operand   = value;
    count_next    = count;
    step_next     = step;
    load          = 1'b0;
    status_next   = ST_OK;
    entry_next    = '0;
    position_next = '0;
    last_next     = 1'b1;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (accept) begin
          case (mode)
            MODE_INSERT: begin
              load = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                cmd.op        = CELL_INSERT;
                count_next    = count + 1'b1;
                position_next = POS_W'(lb_pos);
              end
            end
            MODE_DELETE, MODE_SEARCH: begin
              load = 1'b1;
              if (!found) begin
                status_next = ST_NOT_FOUND;
              end else begin
                position_next = POS_W'(lb_pos);
                if (mode == MODE_DELETE) begin
                  cmd.op     = CELL_DELETE;
                  count_next = count - 1'b1;
                end else begin
                  entry_next = value;
                end
              end
            end
            MODE_DUMP_ASC, MODE_DUMP_DESC: begin
              if (count == '0) begin
                load        = 1'b1;
                status_next = ST_EMPTY;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      ST_DUMP_ASC: begin
        entry_next    = head_val;
        position_next = POS_W'(step);
        last_next     = (CNT_W'(step) + 1'b1) == count;
        if (advance) begin
          cmd.op    = CELL_ROT_LEFT;
          load      = emit;
          step_next = step + 1'b1;
        end
      end
      ST_DUMP_DESC: begin
        entry_next    = tail_val;
        position_next = POS_W'(IDX_W'(DEPTH - 1) - step);
        last_next     = step == IDX_W'(DEPTH - 1);
        if (advance) begin
          cmd.op    = CELL_ROT_RIGHT;
          load      = emit;
          step_next = step + 1'b1;
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  // Result register: load a new beat only when the old one has left
  always_ff @(posedge clk) begin
    if (load) begin
      status      <= status_next;
      entry_value <= entry_next;
      position    <= position_next;
      last_of_run <= last_next;
    end
  end

  `SLT_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "entry count above depth")
  `SLT_ASSERT(a_dump_keeps_count, clk, rst, (state != ST_IDLE) |=> (count == $past(count)), "count moved during a dump")
  `SLT_ASSERT(a_full_insert_holds, clk, rst, (accept && mode == MODE_INSERT && count == CNT_W'(DEPTH)) |=> (count == CNT_W'(DEPTH)), "insert into full store changed count")
  `SLT_ASSERT(a_dump_start, clk, rst, (accept && (mode == MODE_DUMP_ASC || mode == MODE_DUMP_DESC) && count != '0) |=> (step == '0 && state != ST_IDLE), "dump did not start at step zero")

endmodule

// File: sv/sorted_list_table_top.sv
// Top level of the sorted list table: a ring of entry cells driven by one controller.
// Depends on slt_pkg, slt_cell and slt_ctrl.
//
//  Channel  Dir  Beat contents
//  s_*      in   tdata[2:0] mode, tdata[34:3] value
//  m_*      out  tdata[1:0] status, tdata[33:2] entry_value, tdata[37:34] position,
//                tlast last_of_run
//
// Insert, delete and search: the cells compare and shift in parallel.
// A dump of a non-empty store rotates the ring once round; output stalls pause it.
// A result waiting on m_tready holds s_tready low; the next beat enters as it leaves.
// Reset empties the store at once; entry contents are not cleared.
module sorted_list_table_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [slt_pkg::IN_W-1:0]     s_tdata,   // mode, value, zero fill
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [slt_pkg::OUT_W-1:0]    m_tdata,   // status, entry_value, position, zero fill
  output logic                         m_tlast
);
  import slt_pkg::*;

  cell_cmd_t               cmd;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]        lt_vec, eq_vec;
  logic [DEPTH-1:0]        left_lt;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] entry_value;
  logic [POS_W-1:0]        position;

  // Chain of cells closed into a ring
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_lt[i] = 1'b1;
    end else begin : g_body
      assign left_lt[i] = lt_vec[i-1];
    end
    slt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (count > CNT_W'(i)),
      .left_lt   (left_lt[i]),
      .left_val  (cell_val[(i + DEPTH - 1) % DEPTH]),
      .right_val (cell_val[(i + 1) % DEPTH]),
      .val       (cell_val[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  slt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .mode        (s_tdata[MODE_W-1:0]),
    .value       (s_tdata[MODE_W +: VAL_W]),
    .lt_vec      (lt_vec),
    .eq_vec      (eq_vec),
    .head_val    (cell_val[0]),
    .tail_val    (cell_val[DEPTH-1]),
    .cmd         (cmd),
    .count       (count),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .status      (status),
    .entry_value (entry_value),
    .position    (position),
    .last_of_run (m_tlast)
  );

  // Pack the result beat, lowest field first
  assign m_tdata = {{(OUT_W - STAT_W - VAL_W - POS_W){1'b0}}, position, entry_value, status};

endmodule
